@@ sv/raeu_pkg.sv @@
// raeu_pkg: shared constants, opcodes and types of the register alu execute unit
// no dependencies; imported by every module of the unit
`default_nettype none

package raeu_pkg;

  localparam int NUM_REGS = 16;
  localparam int PC_INDEX = 15;

  localparam int DATA_W  = 32;
  localparam int FIDX_W  = 4;
  localparam int REG_AW  = (NUM_REGS > 2) ? $clog2(NUM_REGS) : 1;
  localparam int CNT_W   = $clog2(DATA_W);
  localparam int ADV_W   = 3;

  localparam logic [REG_AW-1:0] PC_SLOT = REG_AW'(PC_INDEX % NUM_REGS);

  localparam logic [ADV_W-1:0] ADV_NONE  = ADV_W'(0);
  localparam logic [ADV_W-1:0] ADV_NOOP  = ADV_W'(1);
  localparam logic [ADV_W-1:0] ADV_ALU   = ADV_W'(4);
  localparam logic [ADV_W-1:0] ADV_LOADI = ADV_W'(6);

  typedef enum logic [2:0] {
    OP_NOOP  = 3'd0,
    OP_LOADI = 3'd1,
    OP_JUMP  = 3'd2,
    OP_ADD   = 3'd3,
    OP_SUB   = 3'd4,
    OP_MUL   = 3'd5,
    OP_DIV   = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_WRITE,
    ST_PC_RD,
    ST_PC_WR
  } exec_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_SIGN
  } div_state_e;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } rf_wr_t;

endpackage

`default_nettype wire

@@ sv/raeu_regfile.sv @@
// raeu_regfile: register file memory, two registered read ports, one write port
// per-entry valid bits give the all-zero reset; uses raeu_pkg
`default_nettype none

module raeu_regfile
  import raeu_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rf_wr_t            wr_i,
  input  wire logic [REG_AW-1:0] raddr_a_i,
  input  wire logic [REG_AW-1:0] raddr_b_i,
  output logic      [DATA_W-1:0] rdata_a_o,
  output logic      [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0]   mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_q;
  logic [DATA_W-1:0]   rdata_a_q;
  logic [DATA_W-1:0]   rdata_b_q;
  logic                rvld_a_q;
  logic                rvld_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rvld_a_q <= 1'b0;
      rvld_b_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      rvld_a_q <= vld_q[raddr_a_i];
      rvld_b_q <= vld_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rvld_a_q ? rdata_a_q : '0;
  assign rdata_b_o = rvld_b_q ? rdata_b_q : '0;

endmodule

`default_nettype wire

@@ sv/raeu_divider.sv @@
// raeu_divider: signed 32-bit division truncating toward zero, one quotient bit a cycle
// restoring shift-subtract on magnitudes, sign fixed in a last cycle; uses raeu_pkg
`default_nettype none

module raeu_divider
  import raeu_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] dividend_i,
  input  wire logic [DATA_W-1:0] divisor_i,
  output logic                   done_o,
  output logic      [DATA_W-1:0] quotient_o
);

  div_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic              neg_q, neg_d;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;

  assign rem_sh = {rem_q, quo_q[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    dvs_d      = dvs_q;
    neg_d      = neg_q;
    done_o     = 1'b0;
    quotient_o = neg_q ? (~quo_q + DATA_W'(1)) : quo_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          quo_d   = dividend_i[DATA_W-1] ? (~dividend_i + DATA_W'(1)) : dividend_i;
          dvs_d   = divisor_i[DATA_W-1] ? (~divisor_i + DATA_W'(1)) : divisor_i;
          neg_d   = dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
          rem_d   = '0;
          cnt_d   = CNT_W'(DATA_W - 1);
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (!diff[DATA_W]) begin
          rem_d = diff[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = DIV_SIGN;
        end
      end
      DIV_SIGN: begin
        done_o  = 1'b1;
        state_d = DIV_IDLE;
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/register_alu_execute_unit.sv @@
// register_alu_execute_unit: executes decoded instructions against the register file
// uses raeu_pkg, raeu_regfile and raeu_divider
//
// channel  direction  handshake                  payload
// in       input      in_valid_i / in_stall_o    opcode, dest/src indexes, immediate
// out      output     out_valid_o / out_stall_i  next_pc, write_done/index/value, div flag
//
// an item steps through exec, write, pc read and pc write before its result is registered;
// a nonzero divide waits in div while the divider makes one quotient bit a cycle
// the register file reads in the cycle after its address; the destination is written
// before the pc is read back, advanced and written
// reset clears all registers to zero at once through per-entry valid bits
// a new item is taken while a result waits; a stalled result holds the pc update
`default_nettype none

module register_alu_execute_unit
  import raeu_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        opcode_i,
  input  wire logic [FIDX_W-1:0] dest_index_i,
  input  wire logic [FIDX_W-1:0] src_a_index_i,
  input  wire logic [FIDX_W-1:0] src_b_index_i,
  input  wire logic [DATA_W-1:0] immediate_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [DATA_W-1:0] next_pc_o,
  output logic                   write_done_o,
  output logic      [FIDX_W-1:0] write_index_o,
  output logic      [DATA_W-1:0] write_value_o,
  output logic                   divide_by_zero_o
);

  exec_state_e       state_q, state_d;
  op_e               op_q, op_d;
  logic [FIDX_W-1:0] dest_q, dest_d;
  logic [DATA_W-1:0] imm_q, imm_d;
  logic              a_ok_q, a_ok_d;
  logic              b_ok_q, b_ok_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic              has_dest_q, has_dest_d;
  logic              dz_q, dz_d;
  logic [ADV_W-1:0]  adv_q, adv_d;
  logic              wrote_q, wrote_d;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_pc_q, out_pc_d;
  logic              out_wr_q, out_wr_d;
  logic [FIDX_W-1:0] out_idx_q, out_idx_d;
  logic [DATA_W-1:0] out_val_q, out_val_d;
  logic              out_dz_q, out_dz_d;

  rf_wr_t            rf_wr;
  logic [REG_AW-1:0] raddr_a;
  logic [REG_AW-1:0] raddr_b;
  logic [DATA_W-1:0] rdata_a;
  logic [DATA_W-1:0] rdata_b;
  logic [DATA_W-1:0] op_a;
  logic [DATA_W-1:0] op_b;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;
  logic              dest_ok;
  logic              out_free;
  logic              in_xfer;
  logic [DATA_W-1:0] pc_new;

  raeu_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (rf_wr),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  raeu_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (op_a),
    .divisor_i  (op_b),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign dest_ok    = (32'(dest_q) < NUM_REGS);
  assign op_a       = a_ok_q ? rdata_a : '0;
  assign op_b       = b_ok_q ? rdata_b : '0;
  assign pc_new     = (op_q == OP_JUMP) ? imm_q : (rdata_a + DATA_W'(adv_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    dest_q     <= dest_d;
    imm_q      <= imm_d;
    a_ok_q     <= a_ok_d;
    b_ok_q     <= b_ok_d;
    val_q      <= val_d;
    has_dest_q <= has_dest_d;
    dz_q       <= dz_d;
    adv_q      <= adv_d;
    wrote_q    <= wrote_d;
    out_pc_q   <= out_pc_d;
    out_wr_q   <= out_wr_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_dz_q   <= out_dz_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    dest_d      = dest_q;
    imm_d       = imm_q;
    a_ok_d      = a_ok_q;
    b_ok_d      = b_ok_q;
    val_d       = val_q;
    has_dest_d  = has_dest_q;
    dz_d        = dz_q;
    adv_d       = adv_q;
    wrote_d     = wrote_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_pc_d    = out_pc_q;
    out_wr_d    = out_wr_q;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    out_dz_d    = out_dz_q;
    rf_wr       = '0;
    raddr_a     = REG_AW'(src_a_index_i);
    raddr_b     = REG_AW'(src_b_index_i);
    div_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          op_d       = op_e'(opcode_i);
          dest_d     = dest_index_i;
          imm_d      = immediate_i;
          a_ok_d     = (32'(src_a_index_i) < NUM_REGS);
          b_ok_d     = (32'(src_b_index_i) < NUM_REGS);
          has_dest_d = 1'b0;
          dz_d       = 1'b0;
          wrote_d    = 1'b0;
          val_d      = '0;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_WRITE;
        unique case (op_q)
          OP_LOADI: begin
            has_dest_d = 1'b1;
            val_d      = imm_q;
            adv_d      = ADV_LOADI;
          end
          OP_JUMP: begin
            adv_d = ADV_NONE;
          end
          OP_ADD: begin
            has_dest_d = 1'b1;
            val_d      = op_a + op_b;
            adv_d      = ADV_ALU;
          end
          OP_SUB: begin
            has_dest_d = 1'b1;
            val_d      = op_a - op_b;
            adv_d      = ADV_ALU;
          end
          OP_MUL: begin
            has_dest_d = 1'b1;
            val_d      = op_a * op_b;
            adv_d      = ADV_ALU;
          end
          OP_DIV: begin
            adv_d = ADV_ALU;
            if (op_b == '0) begin
              dz_d = 1'b1;
            end else begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          end
          default: begin
            adv_d = ADV_NOOP;
          end
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          has_dest_d = 1'b1;
          val_d      = div_quo;
          state_d    = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (has_dest_q && dest_ok) begin
          rf_wr.en   = 1'b1;
          rf_wr.addr = REG_AW'(dest_q);
          rf_wr.data = val_q;
          wrote_d    = 1'b1;
        end
        state_d = ST_PC_RD;
      end
      ST_PC_RD: begin
        raddr_a = PC_SLOT;
        state_d = ST_PC_WR;
      end
      ST_PC_WR: begin
        raddr_a = PC_SLOT;
        if (out_free) begin
          rf_wr.en    = 1'b1;
          rf_wr.addr  = PC_SLOT;
          rf_wr.data  = pc_new;
          out_valid_d = 1'b1;
          out_pc_d    = pc_new;
          out_wr_d    = wrote_q;
          out_idx_d   = wrote_q ? dest_q : '0;
          out_val_d   = wrote_q ? val_q : '0;
          out_dz_d    = dz_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign next_pc_o        = out_pc_q;
  assign write_done_o     = out_wr_q;
  assign write_index_o    = out_idx_q;
  assign write_value_o    = out_val_q;
  assign divide_by_zero_o = out_dz_q;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// tb: self-checking testbench of register_alu_execute_unit
// predicts every instruction against its own register file, then checks each result in order
// depends on raeu_pkg and register_alu_execute_unit
`timescale 1ns / 1ps

module tb;
  import raeu_pkg::*;

  localparam logic [2:0] OP_UNDEF = 3'd7;
  localparam logic [2:0] ALU_OPS [4] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};

  typedef struct packed {
    logic [DATA_W-1:0] next_pc;
    logic              write_done;
    logic [FIDX_W-1:0] write_index;
    logic [DATA_W-1:0] write_value;
    logic              divide_by_zero;
  } retire_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [2:0]        opcode_i;
  logic [FIDX_W-1:0] dest_index_i;
  logic [FIDX_W-1:0] src_a_index_i;
  logic [FIDX_W-1:0] src_b_index_i;
  logic [DATA_W-1:0] immediate_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [DATA_W-1:0] next_pc_o;
  logic              write_done_o;
  logic [FIDX_W-1:0] write_index_o;
  logic [DATA_W-1:0] write_value_o;
  logic              divide_by_zero_o;

  logic [DATA_W-1:0] arch_regs [NUM_REGS];
  retire_t           retire_q [$];
  bit                tx_idle_en = 1'b1;
  bit                rx_idle_en = 1'b1;
  int                n_issued = 0;
  int                n_checked = 0;
  int                n_errors = 0;
  int                n_div_zero = 0;
  int                n_pc_dest = 0;

  register_alu_execute_unit DUT (.*);

  always #4 clk_i = ~clk_i;

  function automatic retire_t execute_instr(logic [2:0] op, logic [FIDX_W-1:0] dst,
                                            logic [FIDX_W-1:0] sa, logic [FIDX_W-1:0] sb,
                                            logic [DATA_W-1:0] imm);
    retire_t           r;
    logic [DATA_W-1:0] a, b, val, adv, ma, mb, q;
    logic              has_dest;
    r = '0;
    a = (sa < NUM_REGS) ? arch_regs[sa] : '0;
    b = (sb < NUM_REGS) ? arch_regs[sb] : '0;
    has_dest = 1'b0;
    val = '0;
    adv = DATA_W'(ADV_NOOP);
    case (op)
      OP_LOADI: begin
        has_dest = 1'b1;
        val = imm;
        adv = DATA_W'(ADV_LOADI);
      end
      OP_JUMP: begin
        arch_regs[PC_SLOT] = imm;
        adv = DATA_W'(ADV_NONE);
      end
      OP_ADD: begin
        has_dest = 1'b1;
        val = a + b;
        adv = DATA_W'(ADV_ALU);
      end
      OP_SUB: begin
        has_dest = 1'b1;
        val = a - b;
        adv = DATA_W'(ADV_ALU);
      end
      OP_MUL: begin
        has_dest = 1'b1;
        val = a * b;
        adv = DATA_W'(ADV_ALU);
      end
      OP_DIV: begin
        adv = DATA_W'(ADV_ALU);
        if (b == '0) begin
          r.divide_by_zero = 1'b1;
          n_div_zero++;
        end else begin
          // magnitudes keep the most negative over minus one wrapping
          ma = a[DATA_W-1] ? -a : a;
          mb = b[DATA_W-1] ? -b : b;
          q = ma / mb;
          val = (a[DATA_W-1] != b[DATA_W-1]) ? -q : q;
          has_dest = 1'b1;
        end
      end
      default: adv = DATA_W'(ADV_NOOP);
    endcase
    if (has_dest && dst < NUM_REGS) begin
      arch_regs[dst] = val;
      r.write_done = 1'b1;
      r.write_index = dst;
      r.write_value = val;
      if (dst == PC_SLOT) n_pc_dest++;
    end
    arch_regs[PC_SLOT] = arch_regs[PC_SLOT] + adv;
    r.next_pc = arch_regs[PC_SLOT];
    return r;
  endfunction

  task automatic issue_instr(logic [2:0] op, logic [FIDX_W-1:0] dst, logic [FIDX_W-1:0] sa,
                             logic [FIDX_W-1:0] sb, logic [DATA_W-1:0] imm);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    dest_index_i  <= dst;
    src_a_index_i <= sa;
    src_b_index_i <= sb;
    immediate_i   <= imm;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    retire_q.push_back(execute_instr(op, dst, sa, sb, imm));
    n_issued++;
  endtask

  function automatic logic [DATA_W-1:0] pick_operand();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = 32'd1;
      2: v = 32'hFFFF_FFFF;
      3: v = 32'h8000_0000;
      4: v = 32'h7FFF_FFFF;
      5: v = DATA_W'($urandom_range(0, 255));
      6: v = -DATA_W'($urandom_range(1, 255));
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic test_after_reset();
    issue_instr(OP_NOOP, 4'd0, 4'd0, 4'd0, 32'h0);
    issue_instr(OP_ADD, 4'd0, 4'd1, 4'd14, 32'hFFFF_FFFF);
  endtask

  task automatic test_load_extremes();
    issue_instr(OP_LOADI, 4'd1, 4'd0, 4'd0, 32'h8000_0000);
    issue_instr(OP_LOADI, 4'd2, 4'd15, 4'd15, 32'hFFFF_FFFF);
    issue_instr(OP_LOADI, 4'd3, 4'd0, 4'd0, 32'h7FFF_FFFF);
    issue_instr(OP_LOADI, 4'd4, 4'd0, 4'd0, 32'h0);
    issue_instr(OP_LOADI, 4'd14, 4'd0, 4'd0, 32'hA5A5_A5A5);
    issue_instr(OP_LOADI, 4'd0, 4'd0, 4'd0, 32'h5A5A_5A5A);
  endtask

  task automatic test_alu_ops();
    issue_instr(OP_ADD, 4'd5, 4'd3, 4'd3, 32'h0);
    issue_instr(OP_SUB, 4'd6, 4'd1, 4'd3, 32'h0);
    issue_instr(OP_MUL, 4'd7, 4'd3, 4'd3, 32'h0);
    issue_instr(OP_MUL, 4'd8, 4'd1, 4'd2, 32'h0);
  endtask

  task automatic test_divide();
    issue_instr(OP_DIV, 4'd9, 4'd1, 4'd2, 32'h0);
    issue_instr(OP_DIV, 4'd10, 4'd3, 4'd4, 32'h0);
    issue_instr(OP_LOADI, 4'd11, 4'd0, 4'd0, -32'd7);
    issue_instr(OP_LOADI, 4'd12, 4'd0, 4'd0, 32'd2);
    issue_instr(OP_DIV, 4'd13, 4'd11, 4'd12, 32'h0);
    issue_instr(OP_DIV, 4'd13, 4'd12, 4'd11, 32'h0);
  endtask

  task automatic test_pc_control();
    issue_instr(OP_JUMP, 4'd0, 4'd0, 4'd0, 32'hFFFF_FFFE);
    issue_instr(OP_NOOP, 4'd15, 4'd15, 4'd15, 32'hFFFF_FFFF);
    issue_instr(OP_UNDEF, 4'd3, 4'd3, 4'd3, 32'h1234_5678);
    issue_instr(OP_LOADI, 4'd15, 4'd0, 4'd0, 32'h0000_0100);
    issue_instr(OP_ADD, 4'd15, 4'd15, 4'd2, 32'h0);
    issue_instr(OP_DIV, 4'd15, 4'd1, 4'd4, 32'h0);
    issue_instr(OP_JUMP, 4'd15, 4'd0, 4'd0, 32'h0);
    issue_instr(OP_ADD, 4'd0, 4'd15, 4'd15, 32'h0);
  endtask

  task automatic test_random_programs(int count);
    logic [2:0] op;
    logic [DATA_W-1:0] imm;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      imm = $urandom();
      case ($urandom_range(0, 19)) inside
        [0:4]: begin
          op = OP_LOADI;
          imm = pick_operand();
        end
        [5:15]: op = ALU_OPS[$urandom_range(0, 3)];
        16: op = OP_NOOP;
        17: op = OP_JUMP;
        18: op = OP_UNDEF;
        default: op = OP_LOADI;
      endcase
      issue_instr(op, FIDX_W'($urandom()), FIDX_W'($urandom()), FIDX_W'($urandom()), imm);
    end
  endtask

  initial begin : result_check
    retire_t exp_r;
    int hold;
    hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        n_checked++;
        if (retire_q.size() == 0) begin
          $error("unexpected result transfer, next_pc %h", next_pc_o);
          n_errors++;
        end else begin
          exp_r = retire_q.pop_front();
          if (next_pc_o !== exp_r.next_pc) begin
            $error("next_pc: expected %h, got %h", exp_r.next_pc, next_pc_o);
            n_errors++;
          end
          if (write_done_o !== exp_r.write_done) begin
            $error("write_done: expected %b, got %b", exp_r.write_done, write_done_o);
            n_errors++;
          end
          if (write_index_o !== exp_r.write_index) begin
            $error("write_index: expected %0d, got %0d", exp_r.write_index, write_index_o);
            n_errors++;
          end
          if (write_value_o !== exp_r.write_value) begin
            $error("write_value: expected %h, got %h", exp_r.write_value, write_value_o);
            n_errors++;
          end
          if (divide_by_zero_o !== exp_r.divide_by_zero) begin
            $error("divide_by_zero: expected %b, got %b", exp_r.divide_by_zero,
                   divide_by_zero_o);
            n_errors++;
          end
        end
        hold = rx_idle_en ? $urandom_range(0, 6) : 0;
      end else if (out_valid_o && hold > 0) begin
        hold--;
      end
      out_stall_i <= (hold > 0);
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = OP_NOOP;
    dest_index_i = '0;
    src_a_index_i = '0;
    src_b_index_i = '0;
    immediate_i = '0;
    for (int i = 0; i < NUM_REGS; i++) arch_regs[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_after_reset();
    test_load_extremes();
    test_alu_ops();
    test_divide();
    test_pc_control();
    test_random_programs(1200);
    in_valid_i <= 1'b0;
    while (retire_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("run covered %0d instructions with %0d results checked", n_issued, n_checked);
    $display("divides by zero: %0d, writes to the pc register: %0d", n_div_zero, n_pc_dest);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
